/* rtl/wiof_pkg.sv */
// Package for the window interquartile outlier filter.
// Holds store depth, payload structs, register indexes, controller states and the command struct.
package wiof_pkg;
    localparam int RangeW    = 24;
    localparam int MaxWindow = 49;

    typedef struct packed {
        logic [RangeW-1:0] range_raw;
        logic              is_centre;
        logic              last_sample;
    } t_in_item;

    typedef struct packed {
        logic       keep;
        logic [5:0] valid_count;
    } t_out_item;

    localparam logic [1:0] RegFilterMode    = 2'd0;
    localparam logic [1:0] RegFenceScale    = 2'd1;
    localparam logic [1:0] RegMeanDiffLimit = 2'd2;

    localparam logic [1:0] ModeIqr     = 2'd1;
    localparam logic [1:0] ModeIqrMean = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_RD_Q, ST_CALC0, ST_CALC1, ST_CALC2, ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic insert;
        logic scan_step;
        logic rd_q;
        logic calc0;
        logic calc1;
        logic calc2;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic q_done;
    } t_status;
endpackage

/* rtl/window_iqr_outlier_filter_unit.sv */
// Top level of the window interquartile outlier filter: registers, controller, datapath.
// Depends on wiof_pkg, wiof_ctrl, wiof_datapath, wiof_ram.
//
// Each nonzero item is inserted, while the 49-entry store has room, by walking
// down the RAM, moving each stored entry that exceeds it up by one place. A last
// item then adds four quartile reads from the single RAM read port and the states
// ST_CALC0, ST_CALC1 and ST_CALC2 for multiply and fence arithmetic before the result
// is offered; the next item is taken once the result has left. The store needs no reset.
module window_iqr_outlier_filter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wiof_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wiof_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import wiof_pkg::*;
    logic [1:0]  r_mode;
    logic [7:0]  r_scale;
    logic [23:0] r_limit;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_scale <= 8'd48; r_limit <= 24'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegFilterMode:    r_mode  <= i_cfg_data[1:0];
                RegFenceScale:    r_scale <= i_cfg_data[7:0];
                RegMeanDiffLimit: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wiof_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_last(i_in_item.last_sample),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(status), .o_cmd(cmd)
    );

    wiof_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_item(i_in_item), .i_mode(r_mode), .i_scale(r_scale),
        .i_limit(r_limit), .o_result(o_out_item)
    );
endmodule

/* rtl/wiof_ram.sv */
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module wiof_ram #(
    parameter int Width = 24,
    parameter int Depth = 49
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/wiof_datapath.sv */
// Datapath: sorted store in RAM (insertion by shifting), sums, quartiles and tests.
// Depends on wiof_pkg and wiof_ram.
module wiof_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wiof_pkg::t_cmd      i_cmd,
    output wiof_pkg::t_status   o_status,
    input  wiof_pkg::t_in_item  i_item,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_scale,
    input  logic [23:0]         i_limit,
    output wiof_pkg::t_out_item o_result
);
    import wiof_pkg::*;
    localparam int AW = $clog2(MaxWindow + 1);
    localparam int RA = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
    localparam int SW = RangeW + AW;

    // Insertion: walk from the top down, moving each entry up while it exceeds v.
    logic [AW-1:0] r_cnt;
    logic [SW-1:0] r_sum;
    logic [23:0]   r_centre, r_v;
    logic [AW-1:0] r_pos;      // hole position
    logic          r_ins;      // insertion in progress
    logic          r_rd_pend;  // read of r_pos-1 is in flight
    logic          r_qpend;    // quartile read is in flight
    logic [1:0]    r_qphase;
    logic [23:0]   r_qa;
    logic [25:0]   r_q1x2, r_q3x2;
    logic [33:0]   r_fence;
    logic signed [37:0] r_lo, r_hi;
    logic signed [SW+1:0] r_d, r_lim;

    logic          we;
    logic [RA-1:0] waddr, raddr;
    logic [23:0]   wdata, rdata;

    wiof_ram #(.Width(24), .Depth(MaxWindow)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [AW-1:0] k, k3, qaddr;
    logic          even, big;
    assign k    = r_cnt >> 2;
    assign k3   = (k << 1) + k;
    assign even = ~r_cnt[0];
    assign big  = r_cnt >= AW'(4);

    always_comb begin
        case (r_qphase)
            2'd0: qaddr = k;
            2'd1: qaddr = even ? k - AW'(1) : k;
            2'd2: qaddr = k3;
            default: qaddr = even ? k3 - AW'(1) : k3;
        endcase
    end

    logic [AW-1:0] cnt_m1, pos_m1, pos_m2;
    logic          scan_ok;
    assign cnt_m1  = r_cnt - AW'(1);
    assign pos_m1  = r_pos - AW'(1);
    assign pos_m2  = r_pos - AW'(2);
    assign scan_ok = r_ins && r_rd_pend && (rdata > r_v);

    always_comb begin
        we = 1'b0;
        waddr = r_pos[RA-1:0];
        wdata = r_v;
        raddr = pos_m1[RA-1:0];
        if (i_cmd.insert) raddr = cnt_m1[RA-1:0];
        if (i_cmd.scan_step && r_ins) begin
            if (r_pos == '0 || r_rd_pend) we = 1'b1;
            if (scan_ok) begin
                wdata = rdata;
                raddr = pos_m2[RA-1:0];
            end
        end
        if (i_cmd.rd_q) raddr = qaddr[RA-1:0];
    end

    always_comb begin
        o_status.scan_done = !r_ins || r_pos == '0 || (r_rd_pend && !scan_ok);
        o_status.q_done    = r_qphase == 2'd3 && r_qpend;
    end

    logic [23:0] cin;
    assign cin = i_item.is_centre ? i_item.range_raw : r_centre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_sum <= '0; r_centre <= '0; r_v <= '0; r_pos <= '0;
            r_ins <= 1'b0; r_rd_pend <= 1'b0; r_qpend <= 1'b0; r_qphase <= '0;
            r_qa <= '0; r_q1x2 <= '0; r_q3x2 <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_centre <= cin;
                if (i_item.range_raw != '0 && r_cnt < AW'(MaxWindow)) begin
                    r_v <= i_item.range_raw;
                    r_pos <= r_cnt;
                    r_ins <= 1'b1;
                    r_rd_pend <= r_cnt != '0;
                    r_cnt <= r_cnt + AW'(1);
                    r_sum <= r_sum + SW'(i_item.range_raw);
                end
            end
            if (i_cmd.scan_step && r_ins) begin
                if (r_pos == '0 || (r_rd_pend && !scan_ok)) begin
                    r_ins <= 1'b0;
                    r_rd_pend <= 1'b0;
                end else if (scan_ok) begin
                    r_pos <= pos_m1;
                    r_rd_pend <= r_pos != AW'(1);
                end
            end
            if (i_cmd.rd_q) begin
                if (!r_qpend) begin
                    r_qpend <= 1'b1;
                end else begin
                    if (r_qphase[0] == 1'b0) r_qa <= rdata;
                    else if (r_qphase == 2'd1) r_q1x2 <= 26'(r_qa) + 26'(rdata);
                    else r_q3x2 <= 26'(r_qa) + 26'(rdata);
                    r_qphase <= r_qphase + 2'd1;
                    r_qpend <= 1'b0;
                end
            end
            if (i_cmd.calc0) begin
                if (!big) begin r_q1x2 <= '0; r_q3x2 <= '0; end
                r_qphase <= '0;
            end
            if (i_cmd.clear) begin
                r_cnt <= '0; r_sum <= '0; r_centre <= '0;
            end
        end
    end

    logic [25:0] iqr_x2;
    assign iqr_x2 = r_q3x2 - r_q1x2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_fence <= 34'(iqr_x2) * 34'(i_scale);
            r_d   <= $signed({2'b0, SW'(r_centre) * SW'(r_cnt)}) - $signed({2'b0, r_sum});
            r_lim <= $signed({2'b0, SW'(i_limit) * SW'(r_cnt)});
        end
        if (i_cmd.calc2) begin
            r_lo <= $signed({8'b0, r_q1x2, 4'b0}) - $signed({4'b0, r_fence});
            r_hi <= $signed({8'b0, r_q3x2, 4'b0}) + $signed({4'b0, r_fence});
        end
    end

    logic signed [37:0] c32;
    logic iqr, mean, dneg, keep_flag;
    logic signed [SW+1:0] dabs;
    assign c32  = $signed({9'b0, r_centre, 5'b0});
    assign iqr  = c32 > r_lo && c32 < r_hi;
    assign dneg = r_d < 0;
    assign dabs = dneg ? -r_d : r_d;
    assign mean = r_cnt == '0 || dabs < r_lim;
    always_comb begin
        case (i_mode)
            ModeIqr:     keep_flag = iqr;
            ModeIqrMean: keep_flag = iqr && mean;
            default:     keep_flag = 1'b1;
        endcase
    end
    always_comb begin
        o_result.keep = keep_flag;
        o_result.valid_count = 6'(r_cnt);
    end
endmodule

/* rtl/wiof_ctrl.sv */
// Controller: sequences insertion, quartile reads and the final tests.
// Depends on wiof_pkg.
module wiof_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wiof_pkg::t_status i_status,
    output wiof_pkg::t_cmd    o_cmd
);
    import wiof_pkg::*;
    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_last <= 1'b0;
        end else begin
            r_state <= n_state; r_last <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last = r_last;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.insert = 1'b1;
                    n_last = i_last;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) n_state = r_last ? ST_RD_Q : ST_IDLE;
            end
            ST_RD_Q: begin
                o_cmd.rd_q = 1'b1;
                if (i_status.q_done) n_state = ST_CALC0;
            end
            ST_CALC0: begin o_cmd.calc0 = 1'b1; n_state = ST_CALC1; end
            ST_CALC1: begin o_cmd.calc1 = 1'b1; n_state = ST_CALC2; end
            ST_CALC2: begin o_cmd.calc2 = 1'b1; n_state = ST_OUT; end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("in and out overlap");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
endmodule
